/* rtl/xhf_pkg.sv */
// Shared constants, opcodes, state and control types for the XOR-hashed bit filter.
package xhf_pkg;

	localparam int INDEX_BITS_DEF        = 10;
	localparam int BLOCK_OFFSET_BITS_DEF = 6;
	localparam int HASH_GAP              = 5;

	localparam int OP_W          = 3;
	localparam int ADDR_W        = 64;
	localparam int BIT_INDEX_W   = 10;
	localparam int ENTRY_INDEX_W = 10;
	localparam int SET_TOTAL_W   = 11;

	typedef enum logic [OP_W-1:0] {
		OP_SET   = 3'd0,
		OP_UNSET = 3'd1,
		OP_TEST  = 3'd2,
		OP_READ  = 3'd3,
		OP_WRITE = 3'd4,
		OP_CLEAR = 3'd5
	} op_t;

	typedef enum logic {
		ST_IDLE,
		ST_UPDATE
	} state_t;

	typedef struct packed {
		logic accept;
		logic commit;
	} xhf_cmd_t;

	typedef struct packed {
		logic out_free;
	} xhf_status_t;

endpackage

/* rtl/xhf_ctrl.sv */
// Controller state machine: sequences input beats through row read and write-back.
module xhf_ctrl import xhf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  xhf_status_t status,
	output xhf_cmd_t    cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				if (status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		cmd.accept = 1'b0;
		cmd.commit = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			ST_UPDATE: begin
				cmd.commit = status.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

/* rtl/xhf_datapath.sv */
// Datapath: address hash, filter row memory with row valid flags, set count, result register.
module xhf_datapath import xhf_pkg::*; #(
	parameter int INDEX_BITS        = INDEX_BITS_DEF,
	parameter int BLOCK_OFFSET_BITS = BLOCK_OFFSET_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  xhf_cmd_t                 cmd,
	output xhf_status_t              status,
	input  logic [OP_W-1:0]          op,
	input  logic [ADDR_W-1:0]        address,
	input  logic [BIT_INDEX_W-1:0]   bit_index,
	input  logic                     write_value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [ENTRY_INDEX_W-1:0] entry_index,
	output logic                     bit_value,
	output logic [SET_TOTAL_W-1:0]   set_total
);

	localparam int LINE_BITS   = (INDEX_BITS > 8) ? INDEX_BITS - 8 : 1;
	localparam int ROW_BITS    = INDEX_BITS - LINE_BITS;
	localparam int ROWS        = 2 ** ROW_BITS;
	localparam int ROW_W       = 2 ** LINE_BITS;
	localparam int CNT_W       = INDEX_BITS + 1;
	localparam int FILTER_SIZE = 2 ** INDEX_BITS;
	localparam int HASH_W      = INDEX_BITS + BLOCK_OFFSET_BITS;
	localparam int DIRECT_W    = INDEX_BITS + BIT_INDEX_W;
	localparam int EIDX_W      = INDEX_BITS + ENTRY_INDEX_W;
	localparam int TOTAL_W     = CNT_W + SET_TOTAL_W;
	localparam int SECOND_LSB  = 2 * BLOCK_OFFSET_BITS + HASH_GAP;

	logic [BLOCK_OFFSET_BITS-1:0] first_field;
	logic [HASH_W-1:0]            first_wide;
	logic [INDEX_BITS-1:0]        second_field;
	logic [INDEX_BITS-1:0]        hash_idx;
	logic [DIRECT_W-1:0]          direct_wide;
	logic [INDEX_BITS-1:0]        direct_idx;
	logic [INDEX_BITS-1:0]        idx_in;

	logic [OP_W-1:0]       op_q;
	logic [INDEX_BITS-1:0] idx_q;
	logic                  wval_q;
	logic [ROW_W-1:0]      rd_row_q;

	logic [ROW_W-1:0] mem [ROWS];
	logic [ROWS-1:0]  row_valid_q;
	logic [CNT_W-1:0] count_q;

	logic [ROW_BITS-1:0]  row_sel;
	logic [LINE_BITS-1:0] col_sel;
	logic [ROW_W-1:0]     old_row;
	logic [ROW_W-1:0]     new_row;
	logic                 old_bit;
	logic                 new_bit;
	logic                 wr_en;
	logic                 clr_all;
	logic                 res_bit;
	logic [CNT_W-1:0]     count_d;

	logic                     out_valid_q;
	logic [ENTRY_INDEX_W-1:0] entry_index_q;
	logic                     bit_value_q;
	logic [SET_TOTAL_W-1:0]   set_total_q;

	logic [EIDX_W-1:0]  eidx_wide;
	logic [TOTAL_W-1:0] total_wide;

	assign first_field  = address[BLOCK_OFFSET_BITS +: BLOCK_OFFSET_BITS];
	assign first_wide   = HASH_W'(first_field);
	assign second_field = address[SECOND_LSB +: INDEX_BITS];
	assign hash_idx     = first_wide[INDEX_BITS-1:0] ^ second_field;
	assign direct_wide  = DIRECT_W'(bit_index);
	assign direct_idx   = direct_wide[INDEX_BITS-1:0];

	always_comb begin
		case (op_t'(op))
			OP_SET, OP_UNSET, OP_TEST: idx_in = hash_idx;
			OP_READ, OP_WRITE:         idx_in = direct_idx;
			default:                   idx_in = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q   <= op;
			idx_q  <= idx_in;
			wval_q <= write_value;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			rd_row_q <= mem[idx_in[INDEX_BITS-1:LINE_BITS]];
		end
	end

	assign row_sel = idx_q[INDEX_BITS-1:LINE_BITS];
	assign col_sel = idx_q[LINE_BITS-1:0];
	assign old_row = row_valid_q[row_sel] ? rd_row_q : '0;
	assign old_bit = old_row[col_sel];

	always_comb begin
		wr_en   = 1'b0;
		clr_all = 1'b0;
		new_bit = old_bit;
		res_bit = 1'b0;
		case (op_t'(op_q))
			OP_SET: begin
				wr_en   = 1'b1;
				new_bit = 1'b1;
				res_bit = 1'b1;
			end
			OP_UNSET: begin
				wr_en   = 1'b1;
				new_bit = 1'b0;
				res_bit = 1'b0;
			end
			OP_TEST, OP_READ: begin
				res_bit = old_bit;
			end
			OP_WRITE: begin
				wr_en   = 1'b1;
				new_bit = wval_q;
				res_bit = wval_q;
			end
			OP_CLEAR: begin
				clr_all = 1'b1;
			end
			default: begin
				res_bit = 1'b0;
			end
		endcase
	end

	always_comb begin
		new_row          = old_row;
		new_row[col_sel] = new_bit;
	end

	always_comb begin
		count_d = count_q;
		if (clr_all) begin
			count_d = '0;
		end else if (wr_en && (old_bit != new_bit)) begin
			if (new_bit) begin
				count_d = count_q + CNT_W'(1);
			end else begin
				count_d = count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && wr_en) begin
			mem[row_sel] <= new_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			count_q     <= '0;
		end else if (cmd.commit) begin
			count_q <= count_d;
			if (clr_all) begin
				row_valid_q <= '0;
			end else if (wr_en) begin
				row_valid_q[row_sel] <= 1'b1;
			end
		end
	end

	assign eidx_wide  = EIDX_W'(idx_q);
	assign total_wide = TOTAL_W'(count_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			entry_index_q <= eidx_wide[ENTRY_INDEX_W-1:0];
			bit_value_q   <= res_bit;
			set_total_q   <= total_wide[SET_TOTAL_W-1:0];
		end
	end

	assign status.out_free = !out_valid_q || out_ready;
	assign out_valid       = out_valid_q;
	assign entry_index     = entry_index_q;
	assign bit_value       = bit_value_q;
	assign set_total       = set_total_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(FILTER_SIZE))
		else $error("set count beyond filter size");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid_q || out_ready))
		else $error("result beat overwritten before taken");

	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q)
		else $error("committed result not presented");

	a_clear_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && clr_all) |=> (count_q == '0 && row_valid_q == '0))
		else $error("clear all left state behind");

	a_one_phase: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.accept && cmd.commit))
		else $error("accept and commit in one cycle");

endmodule

/* rtl/xor_hashed_address_bit_filter_core.sv */
// Top level of the XOR-hashed address bit filter: controller plus datapath.
// For each input beat, the row holding the entry is read from the filter memory when
// the beat is accepted in ST_IDLE; then in ST_UPDATE, once the output register is free,
// the row is written back, the set count updated and the result loaded into the output
// register. A new beat is accepted only after ST_UPDATE has committed the last one;
// a result waiting on out_ready holds back the write-back of the next item.
// Clear all takes effect at its commit through per-row valid flags, and the filter
// needs no clearing pass after reset.
module xor_hashed_address_bit_filter_core import xhf_pkg::*; #(
	parameter int INDEX_BITS        = INDEX_BITS_DEF,
	parameter int BLOCK_OFFSET_BITS = BLOCK_OFFSET_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [OP_W-1:0]          op,
	input  logic [ADDR_W-1:0]        address,
	input  logic [BIT_INDEX_W-1:0]   bit_index,
	input  logic                     write_value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [ENTRY_INDEX_W-1:0] entry_index,
	output logic                     bit_value,
	output logic [SET_TOTAL_W-1:0]   set_total
);

	xhf_cmd_t    cmd;
	xhf_status_t status;

	xhf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	xhf_datapath #(
		.INDEX_BITS        (INDEX_BITS),
		.BLOCK_OFFSET_BITS (BLOCK_OFFSET_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.op          (op),
		.address     (address),
		.bit_index   (bit_index),
		.write_value (write_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.entry_index (entry_index),
		.bit_value   (bit_value),
		.set_total   (set_total)
	);

endmodule
